/* hdl/sdpm_pkg.sv */
// ----------------------------------------------------------------------------
// sdpm_pkg
// Shared constants, types and arithmetic helpers for the stereo delay,
// polarity and pan mixer.
// ----------------------------------------------------------------------------
package sdpm_pkg;

    localparam int SAMPLE_W    = 24;
    localparam int DELAY_DEPTH = 524288;
    localparam int ADDR_W      = $clog2(DELAY_DEPTH);
    localparam int DELAY_W     = 19;
    localparam int Q_W         = 16;
    localparam int GAIN_W      = 17;
    localparam int COEF_W      = 18;
    localparam int LANE_PROD_W = SAMPLE_W + GAIN_W;
    localparam int MIX_PROD_W  = SAMPLE_W + COEF_W;
    localparam int ACC_W       = 48;
    localparam int CFG_DATA_W  = 19;
    localparam int CFG_IDX_W   = 2;

    localparam logic [Q_W-1:0] Q_ONE = 16'd32768;

    localparam logic signed [ACC_W-1:0] RND_HALF = 48'sd16384;
    localparam logic signed [ACC_W-1:0] SAT_HI   = (48'sd1 <<< (SAMPLE_W - 1)) - 48'sd1;
    localparam logic signed [ACC_W-1:0] SAT_LO   = -(48'sd1 <<< (SAMPLE_W - 1));

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DELAY     = 2'd0,
        REG_PHASE     = 2'd1,
        REG_LEFT_PAN  = 2'd2,
        REG_RIGHT_PAN = 2'd3
    } cfg_reg_t;

    // ring access for one beat, shared by both lanes
    typedef struct packed {
        logic              step;
        logic              bypass;
        logic [ADDR_W-1:0] wr_addr;
        logic [ADDR_W-1:0] rd_addr;
        logic              rd_known;
    } ring_ctl_t;

    typedef struct packed {
        logic                clip;
        logic [SAMPLE_W-1:0] value;
    } sat_t;

    function automatic logic [Q_W-1:0] clamp_q(input logic [Q_W-1:0] v);
        return (v > Q_ONE) ? Q_ONE : v;
    endfunction

    // q15 rounding, halves toward plus infinity, then saturate
    function automatic sat_t round_sat(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] t;
        sat_t                    r;
        t = (v + RND_HALF) >>> 15;
        if (t > SAT_HI) begin
            r.clip  = 1'b1;
            r.value = SAT_HI[SAMPLE_W-1:0];
        end else if (t < SAT_LO) begin
            r.clip  = 1'b1;
            r.value = SAT_LO[SAMPLE_W-1:0];
        end else begin
            r.clip  = 1'b0;
            r.value = t[SAMPLE_W-1:0];
        end
        return r;
    endfunction

endpackage

/* hdl/stereo_delay_polarity_pan_mixer_core.sv */
// gain multiply, ring access, pan multiply, then round and saturate into the
// output register; one beat in flight at a time, so a new input is taken only
// after the last beat reaches the output register, where it may still wait.
// reset: registers back to delay 0, no polarity flip, identity pan; ring has
// no clearing pass, a fill mark (write pointer plus wrap flag) makes entries
// never written read as zero, so the block is ready straight after reset
// ----------------------------------------------------------------------------
// stereo_delay_polarity_pan_mixer_core
// Stereo polarity blend, per-channel delay ring and 2x2 pan matrix with
// saturation flag. Two channel lanes feed a shared mixing stage.
// ----------------------------------------------------------------------------
module stereo_delay_polarity_pan_mixer_core (
    input  logic                                  aclk,
    input  logic                                  aresetn,

    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [sdpm_pkg::SAMPLE_W-1:0]  s_left_in,
    input  logic signed [sdpm_pkg::SAMPLE_W-1:0]  s_right_in,

    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [sdpm_pkg::SAMPLE_W-1:0]  m_left_out,
    output logic signed [sdpm_pkg::SAMPLE_W-1:0]  m_right_out,
    output logic                                  m_clipped,

    input  logic                                  cfg_we,
    input  logic        [sdpm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic        [sdpm_pkg::CFG_DATA_W-1:0] cfg_data
);

    logic [sdpm_pkg::DELAY_W-1:0] delay_reg;
    logic [sdpm_pkg::Q_W-1:0]     phase_reg;
    logic [sdpm_pkg::Q_W-1:0]     lpan_reg;
    logic [sdpm_pkg::Q_W-1:0]     rpan_reg;

    logic                         v1_reg, v2_reg, v3_reg;
    logic                         m_valid_reg;
    logic                         accept;
    logic                         out_load;

    logic [sdpm_pkg::ADDR_W-1:0]  wp_reg;
    logic                         wrapped_reg;
    logic [sdpm_pkg::ADDR_W-1:0]  rd_addr;
    logic                         bypass;
    sdpm_pkg::ring_ctl_t          ring_ctl;

    logic [sdpm_pkg::Q_W-1:0]     phase_c;
    logic [sdpm_pkg::GAIN_W:0]    gain_wide;
    logic signed [sdpm_pkg::GAIN_W-1:0] gain;

    logic signed [sdpm_pkg::SAMPLE_W-1:0] left_d;
    logic signed [sdpm_pkg::SAMPLE_W-1:0] right_d;
    logic                                 left_clip;
    logic                                 right_clip;
    sdpm_pkg::sat_t                       left_res;
    sdpm_pkg::sat_t                       right_res;

    logic [sdpm_pkg::SAMPLE_W-1:0] left_out_reg;
    logic [sdpm_pkg::SAMPLE_W-1:0] right_out_reg;
    logic                          clipped_reg;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_reg <= '0;
            phase_reg <= '0;
            lpan_reg  <= '0;
            rpan_reg  <= sdpm_pkg::Q_ONE;
        end else if (cfg_we) begin
            case (cfg_index)
                sdpm_pkg::REG_DELAY:     delay_reg <= cfg_data[sdpm_pkg::DELAY_W-1:0];
                sdpm_pkg::REG_PHASE:     phase_reg <= cfg_data[sdpm_pkg::Q_W-1:0];
                sdpm_pkg::REG_LEFT_PAN:  lpan_reg  <= cfg_data[sdpm_pkg::Q_W-1:0];
                sdpm_pkg::REG_RIGHT_PAN: rpan_reg  <= cfg_data[sdpm_pkg::Q_W-1:0];
                default: ;
            endcase
        end
    end

    // gain = 1 - 2*phase in q1.15
    assign phase_c   = sdpm_pkg::clamp_q(phase_reg);
    assign gain_wide = (sdpm_pkg::GAIN_W + 1)'(sdpm_pkg::Q_ONE) - {1'b0, phase_c, 1'b0};
    assign gain      = $signed(gain_wide[sdpm_pkg::GAIN_W-1:0]);

    // one beat in flight; last stage holds while the output is full
    assign s_ready  = !(v1_reg || v2_reg || v3_reg);
    assign accept   = s_valid && s_ready;
    assign out_load = v3_reg && (!m_valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            v1_reg <= accept;
            v2_reg <= v1_reg;
            if (v2_reg) begin
                v3_reg <= 1'b1;
            end else if (out_load) begin
                v3_reg <= 1'b0;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // ring pointer and fill mark
    assign bypass  = (delay_reg == '0);
    assign rd_addr = wp_reg - sdpm_pkg::ADDR_W'(delay_reg);

    assign ring_ctl.step     = v1_reg;
    assign ring_ctl.bypass   = bypass;
    assign ring_ctl.wr_addr  = wp_reg;
    assign ring_ctl.rd_addr  = rd_addr;
    assign ring_ctl.rd_known = wrapped_reg || (rd_addr <= wp_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg      <= '0;
            wrapped_reg <= 1'b0;
        end else if (v1_reg && !bypass) begin
            wp_reg <= wp_reg + 1'b1;
            if (wp_reg == '1) begin
                wrapped_reg <= 1'b1;
            end
        end
    end

    sdpm_lane u_lane_left (
        .aclk       (aclk),
        .load       (accept),
        .sample_in  (s_left_in),
        .gain       (gain),
        .ctl        (ring_ctl),
        .sample_out (left_d),
        .clip       (left_clip)
    );

    sdpm_lane u_lane_right (
        .aclk       (aclk),
        .load       (accept),
        .sample_in  (s_right_in),
        .gain       (gain),
        .ctl        (ring_ctl),
        .sample_out (right_d),
        .clip       (right_clip)
    );

    sdpm_mix u_mix (
        .aclk      (aclk),
        .load      (v2_reg),
        .a         (left_d),
        .b         (right_d),
        .lp        (sdpm_pkg::clamp_q(lpan_reg)),
        .rp        (sdpm_pkg::clamp_q(rpan_reg)),
        .left_res  (left_res),
        .right_res (right_res)
    );

    always_ff @(posedge aclk) begin
        if (out_load) begin
            left_out_reg  <= left_res.value;
            right_out_reg <= right_res.value;
            clipped_reg   <= left_clip || right_clip || left_res.clip || right_res.clip;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_left_out  = $signed(left_out_reg);
    assign m_right_out = $signed(right_out_reg);
    assign m_clipped   = clipped_reg;

    // at most one beat between input and output register
    assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({v1_reg, v2_reg, v3_reg}))
        else $error("more than one beat in the pipeline");

    // a finished beat waits while the output register is still full
    assert property (@(posedge aclk) disable iff (!aresetn)
        (v3_reg && m_valid_reg && !m_ready) |=> (v3_reg && m_valid_reg))
        else $error("finished beat lost while output stalled");

    // bypass leaves the ring pointer alone
    assert property (@(posedge aclk) disable iff (!aresetn)
        (v1_reg && bypass) |=> $stable(wp_reg))
        else $error("write pointer moved in bypass");

    // fill mark only ever grows
    assert property (@(posedge aclk) disable iff (!aresetn)
        !$fell(wrapped_reg))
        else $error("ring wrap flag cleared outside reset");

endmodule

/* hdl/sdpm_lane.sv */
// ----------------------------------------------------------------------------
// sdpm_lane
// One channel: polarity gain, rounding and saturation, then the ring buffer
// write and delayed read.
// ----------------------------------------------------------------------------
module sdpm_lane (
    input  logic                                  aclk,
    input  logic                                  load,
    input  logic signed [sdpm_pkg::SAMPLE_W-1:0]  sample_in,
    input  logic signed [sdpm_pkg::GAIN_W-1:0]    gain,
    input  sdpm_pkg::ring_ctl_t                   ctl,
    output logic signed [sdpm_pkg::SAMPLE_W-1:0]  sample_out,
    output logic                                  clip
);

    logic [sdpm_pkg::SAMPLE_W-1:0] mem [sdpm_pkg::DELAY_DEPTH];

    logic signed [sdpm_pkg::LANE_PROD_W-1:0] s_ext;
    logic signed [sdpm_pkg::LANE_PROD_W-1:0] g_ext;
    logic signed [sdpm_pkg::LANE_PROD_W-1:0] prod_reg;
    sdpm_pkg::sat_t                          scaled;

    logic [sdpm_pkg::SAMPLE_W-1:0] scaled_reg;
    logic [sdpm_pkg::SAMPLE_W-1:0] rdata_reg;
    logic                          clip_reg;
    logic                          bypass_reg;
    logic                          same_reg;
    logic                          known_reg;

    assign s_ext  = sdpm_pkg::LANE_PROD_W'(sample_in);
    assign g_ext  = sdpm_pkg::LANE_PROD_W'(gain);
    assign scaled = sdpm_pkg::round_sat(sdpm_pkg::ACC_W'(prod_reg));

    always_ff @(posedge aclk) begin
        if (load) begin
            prod_reg <= s_ext * g_ext;
        end
    end

    // read-before-write port, same address is forwarded below
    always_ff @(posedge aclk) begin
        if (ctl.step) begin
            scaled_reg <= scaled.value;
            clip_reg   <= scaled.clip;
            bypass_reg <= ctl.bypass;
            same_reg   <= (ctl.rd_addr == ctl.wr_addr);
            known_reg  <= ctl.rd_known;
            rdata_reg  <= mem[ctl.rd_addr];
            if (!ctl.bypass) begin
                mem[ctl.wr_addr] <= scaled.value;
            end
        end
    end

    always_comb begin
        if (bypass_reg || same_reg) begin
            sample_out = $signed(scaled_reg);
        end else if (known_reg) begin
            sample_out = $signed(rdata_reg);
        end else begin
            // never written since reset
            sample_out = '0;
        end
    end

    assign clip = clip_reg;

endmodule

/* hdl/sdpm_mix.sv */
// ----------------------------------------------------------------------------
// sdpm_mix
// Merging stage: 2x2 pan matrix across the two lanes with rounding and
// saturation.
// ----------------------------------------------------------------------------
module sdpm_mix (
    input  logic                                  aclk,
    input  logic                                  load,
    input  logic signed [sdpm_pkg::SAMPLE_W-1:0]  a,
    input  logic signed [sdpm_pkg::SAMPLE_W-1:0]  b,
    input  logic        [sdpm_pkg::Q_W-1:0]       lp,
    input  logic        [sdpm_pkg::Q_W-1:0]       rp,
    output sdpm_pkg::sat_t                        left_res,
    output sdpm_pkg::sat_t                        right_res
);

    logic signed [sdpm_pkg::MIX_PROD_W-1:0] a_ext;
    logic signed [sdpm_pkg::MIX_PROD_W-1:0] b_ext;
    logic signed [sdpm_pkg::MIX_PROD_W-1:0] lp_c;
    logic signed [sdpm_pkg::MIX_PROD_W-1:0] rp_c;
    logic signed [sdpm_pkg::MIX_PROD_W-1:0] lk_c;
    logic signed [sdpm_pkg::MIX_PROD_W-1:0] rk_c;

    logic signed [sdpm_pkg::MIX_PROD_W-1:0] al_reg;
    logic signed [sdpm_pkg::MIX_PROD_W-1:0] bl_reg;
    logic signed [sdpm_pkg::MIX_PROD_W-1:0] ar_reg;
    logic signed [sdpm_pkg::MIX_PROD_W-1:0] br_reg;

    logic signed [sdpm_pkg::ACC_W-1:0] left_sum;
    logic signed [sdpm_pkg::ACC_W-1:0] right_sum;

    assign a_ext = sdpm_pkg::MIX_PROD_W'(a);
    assign b_ext = sdpm_pkg::MIX_PROD_W'(b);
    assign lp_c  = $signed(sdpm_pkg::MIX_PROD_W'(lp));
    assign rp_c  = $signed(sdpm_pkg::MIX_PROD_W'(rp));
    assign lk_c  = $signed(sdpm_pkg::MIX_PROD_W'(sdpm_pkg::Q_ONE) -
                           sdpm_pkg::MIX_PROD_W'(lp));
    assign rk_c  = $signed(sdpm_pkg::MIX_PROD_W'(sdpm_pkg::Q_ONE) -
                           sdpm_pkg::MIX_PROD_W'(rp));

    always_ff @(posedge aclk) begin
        if (load) begin
            al_reg <= a_ext * lk_c;
            bl_reg <= b_ext * rk_c;
            ar_reg <= a_ext * lp_c;
            br_reg <= b_ext * rp_c;
        end
    end

    assign left_sum  = sdpm_pkg::ACC_W'(al_reg) + sdpm_pkg::ACC_W'(bl_reg);
    assign right_sum = sdpm_pkg::ACC_W'(ar_reg) + sdpm_pkg::ACC_W'(br_reg);

    assign left_res  = sdpm_pkg::round_sat(left_sum);
    assign right_res = sdpm_pkg::round_sat(right_sum);

endmodule
